### src/single_float_multiply_assert.svh
// Assertion macros used by the checker file.
`ifndef SINGLE_FLOAT_MULTIPLY_ASSERT_SVH
`define SINGLE_FLOAT_MULTIPLY_ASSERT_SVH

// Immediate implication: if antecedent holds, consequent holds in the same cycle.
`define SFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared widths and constants of the single-precision multiplier.
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ExpW   = 8;
  localparam int unsigned HiW    = 13;
  localparam int unsigned LoW    = 11;
  localparam int unsigned SumW   = 26;
  localparam int unsigned ExpSumW = 10;

  localparam logic [ExpSumW-1:0] ExpOffset = 10'd129;
  localparam logic [HiW-1:0]     HidBit    = 13'h1000;

  // stage 1 -> stage 2 payload
  typedef struct packed {
    logic                 sign;
    logic [ExpSumW-1:0]   exp_sum;
    logic [2*HiW-1:0]     hh;
    logic [HiW+LoW-1:0]   hl;
    logic [HiW+LoW-1:0]   lh;
  } s1_t;

  // stage 2 -> stage 3 payload
  typedef struct packed {
    logic                 sign;
    logic [ExpSumW-1:0]   exp_sum;
    logic [SumW-1:0]      sum;
  } s2_t;

endpackage

### src/sfm_if.sv
// ----------------------------------------------------------------------------
// sfm_in_if / sfm_out_if
// Valid/ready channels of the multiplier.
// ----------------------------------------------------------------------------
interface sfm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface sfm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] product;
  modport source (output valid, output product, input ready);
  modport sink (input valid, input product, output ready);
endinterface

### src/sfm_mul_stage.sv
// ----------------------------------------------------------------------------
// sfm_mul_stage
// Stage 1: unpack operands, form the three partial products.
// ----------------------------------------------------------------------------
module sfm_mul_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [sfm_pkg::WordW-1:0]   a_i,
  input  logic [sfm_pkg::WordW-1:0]   b_i,
  output logic                        valid_o,
  output sfm_pkg::s1_t                data_o
);

  logic [sfm_pkg::HiW-1:0] ha, hb;
  logic [sfm_pkg::LoW-1:0] la, lb;
  sfm_pkg::s1_t            data_d, data_q;
  logic                    valid_q;

  always_comb begin
    ha = {1'b0, a_i[22:11]} | sfm_pkg::HidBit;
    hb = {1'b0, b_i[22:11]} | sfm_pkg::HidBit;
    la = a_i[10:0];
    lb = b_i[10:0];
    data_d.sign    = a_i[31] ^ b_i[31];
    data_d.exp_sum = {2'b00, a_i[30:23]} + {2'b00, b_i[30:23]} + sfm_pkg::ExpOffset;
    data_d.hh      = ha * hb;
    data_d.hl      = ha * lb;
    data_d.lh      = la * hb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### src/sfm_sum_stage.sv
// ----------------------------------------------------------------------------
// sfm_sum_stage
// Stage 2: add the partial products and the rounding constant.
// ----------------------------------------------------------------------------
module sfm_sum_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  sfm_pkg::s1_t data_i,
  output logic         valid_o,
  output sfm_pkg::s2_t data_o
);

  sfm_pkg::s2_t data_d, data_q;
  logic         valid_q;

  always_comb begin
    data_d.sign    = data_i.sign;
    data_d.exp_sum = data_i.exp_sum;
    data_d.sum     = data_i.hh
                   + {13'd0, data_i.hl[23:11]}
                   + {13'd0, data_i.lh[23:11]}
                   + 26'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### src/sfm_pack_stage.sv
// ----------------------------------------------------------------------------
// sfm_pack_stage
// Stage 3: normalize, select exponent, flush out-of-range exponents to signed zero.
// ----------------------------------------------------------------------------
module sfm_pack_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  sfm_pkg::s2_t              data_i,
  output logic                      valid_o,
  output logic [sfm_pkg::WordW-1:0] product_o
);

  logic [sfm_pkg::WordW-1:0] product_d, product_q;
  logic [sfm_pkg::ExpW-1:0]  expo;
  logic [22:0]               mant;
  logic                      valid_q;

  always_comb begin
    // sum at or above 2^25: shift by one more and bump the exponent
    if (data_i.sum[25]) begin
      mant = data_i.sum[24:2];
      expo = data_i.exp_sum[7:0] + 8'd1;
    end else begin
      mant = data_i.sum[23:1];
      expo = data_i.exp_sum[7:0];
    end
    // bit 8 clear: out of range, signed zero
    if (!data_i.exp_sum[8]) begin
      product_d = {data_i.sign, 31'd0};
    end else begin
      product_d = {data_i.sign, expo, mant};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      product_q <= product_d;
    end
  end

  assign valid_o   = valid_q;
  assign product_o = product_q;

endmodule

### src/single_float_multiply.sv
// ----------------------------------------------------------------------------
// single_float_multiply
// Three-stage single-precision multiplier with valid/ready channels.
// ----------------------------------------------------------------------------
// Takes one operand pair per clock while the output is not stalled; the product
// passes through three register stages (partial products, sum, normalize/pack).
// A stall on the output freezes each full stage whose successor cannot move; an
// empty stage keeps filling, so no bubble is held while the output waits.
module single_float_multiply (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfm_in_if.sink    in_i,
  sfm_out_if.source out_o
);

  logic         v1, v2, v3;
  logic         en1, en2, en3;
  sfm_pkg::s1_t d1;
  sfm_pkg::s2_t d2;

  // each stage advances when it is empty or its successor moves
  assign en3 = !v3 || out_o.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_i.ready = en1;

  sfm_mul_stage u_mul (
    .clk_i, .rst_ni, .en_i(en1), .valid_i(in_i.valid),
    .a_i(in_i.operand_a), .b_i(in_i.operand_b), .valid_o(v1), .data_o(d1)
  );

  sfm_sum_stage u_sum (
    .clk_i, .rst_ni, .en_i(en2), .valid_i(v1), .data_i(d1),
    .valid_o(v2), .data_o(d2)
  );

  sfm_pack_stage u_pack (
    .clk_i, .rst_ni, .en_i(en3), .valid_i(v2), .data_i(d2),
    .valid_o(v3), .product_o(out_o.product)
  );

  assign out_o.valid = v3;

endmodule

### src/sfm_checker.sv
// ----------------------------------------------------------------------------
// sfm_checker
// Port-level checks of the multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`include "single_float_multiply_assert.svh"

module sfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] product_i
);

  `SFM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(product_i))
  `SFM_ASSERT_IMP(a_ready_when_drain, clk_i, rst_ni, out_ready_i, in_ready_i)
  `SFM_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)
  `SFM_ASSERT_NXT(a_three_later, clk_i, rst_ni, in_valid_i && in_ready_i && out_ready_i, ##2 out_valid_i)

endmodule

bind single_float_multiply sfm_checker u_sfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .product_i   (out_o.product)
);
